>>> sv/pcg_pkg.sv
// pcg_pkg: shared types, fixed-point constants and helpers for the preset color grading core
// also holds the elaboration-time builder for the power-curve tables
// no dependencies
`default_nettype none

package pcg_pkg;

  // fixed-point format of every channel value
  localparam int FRAC_BITS          = 12;
  localparam int PIX_W              = FRAC_BITS + 1;
  localparam int ONE                = 1 << FRAC_BITS;
  localparam int HALF               = 1 << (FRAC_BITS - 1);
  localparam int VAL_W              = 20;
  localparam int K_W                = 16;
  localparam int POW_TABLE_BITS_DEF = 8;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [K_W-1:0]   coef_t;
  typedef logic [PIX_W-1:0]        pix_t;

  // preset codes
  localparam logic [1:0] PRESET_PUNCHY = 2'd0;
  localparam logic [1:0] PRESET_WARM   = 2'd1;

  // curve exponents, times 10000
  localparam int EXP_P092 = 9200;
  localparam int EXP_P108 = 10800;
  localparam int EXP_P104 = 10400;
  localparam int EXP_P096 = 9600;

  // rounded Q-format coefficients
  localparam coef_t K_LUM_R = K_W'((2126 * ONE + 5000) / 10000);
  localparam coef_t K_LUM_G = K_W'((7152 * ONE + 5000) / 10000);
  localparam coef_t K_LUM_B = K_W'((722 * ONE + 5000) / 10000);
  localparam coef_t K_SAT0  = K_W'((10800 * ONE + 5000) / 10000);
  localparam coef_t K_CON0  = K_W'((10600 * ONE + 5000) / 10000);
  localparam coef_t K_RG0   = K_W'((10150 * ONE + 5000) / 10000);
  localparam coef_t K_BG0   = K_W'((9850 * ONE + 5000) / 10000);
  localparam coef_t K_SAT1  = K_W'((8800 * ONE + 5000) / 10000);
  localparam coef_t K_SH1_R = K_W'((150 * ONE + 5000) / 10000);
  localparam coef_t K_HL1_R = K_W'((450 * ONE + 5000) / 10000);
  localparam coef_t K_SH1_G = K_W'((350 * ONE + 5000) / 10000);
  localparam coef_t K_HL1_G = K_W'((250 * ONE + 5000) / 10000);
  localparam coef_t K_SH1_B = K_W'((500 * ONE + 5000) / 10000);
  localparam coef_t K_G2_R  = K_W'((8000 * ONE + 5000) / 10000);
  localparam coef_t K_G2_G  = K_W'((9300 * ONE + 5000) / 10000);
  localparam coef_t K_G2_B  = K_W'((11200 * ONE + 5000) / 10000);
  localparam coef_t K_SAT2  = K_W'((11800 * ONE + 5000) / 10000);
  localparam coef_t K_SH2_R = K_W'((180 * ONE + 5000) / 10000);
  localparam coef_t K_HL2_R = K_W'((350 * ONE + 5000) / 10000);
  localparam coef_t K_SH2_G = K_W'((450 * ONE + 5000) / 10000);
  localparam coef_t K_HL2_G = K_W'((200 * ONE + 5000) / 10000);
  localparam coef_t K_SH2_B = K_W'((1100 * ONE + 5000) / 10000);
  localparam coef_t K_HL2_B = K_W'((450 * ONE + 5000) / 10000);

  localparam val_t ONE_V  = VAL_W'(ONE);
  localparam val_t HALF_V = VAL_W'(HALF);

  // constant multiply, rounded to nearest with ties away from zero
  function automatic val_t mulk(input val_t a, input coef_t k);
    logic signed [VAL_W+K_W-1:0] p;
    logic [VAL_W+K_W-1:0]        m;
    logic [VAL_W+K_W-1:0]        r;
    p = a * k;
    m = p[VAL_W+K_W-1] ? (VAL_W+K_W)'(-p) : (VAL_W+K_W)'(p);
    r = (m + (VAL_W+K_W)'(HALF)) >> FRAC_BITS;
    return p[VAL_W+K_W-1] ? -VAL_W'(r) : VAL_W'(r);
  endfunction

  function automatic val_t clamp01(input val_t v);
    if (v < 0) return '0;
    if (v > ONE_V) return ONE_V;
    return v;
  endfunction

  function automatic val_t to_val(input pix_t x);
    return val_t'({{(VAL_W-PIX_W){1'b0}}, x});
  endfunction

  function automatic val_t luma(input val_t r, input val_t g, input val_t b);
    return mulk(r, K_LUM_R) + mulk(g, K_LUM_G) + mulk(b, K_LUM_B);
  endfunction

  // elaboration-time helpers for the power tables (Q30 fixed point)
  function automatic longint unsigned isqrt64(input longint unsigned n_in);
    longint unsigned n;
    longint unsigned r;
    longint unsigned bt;
    n  = n_in;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q30(input longint unsigned i);
    int              n;
    int              b;
    longint unsigned y;
    longint unsigned res;
    n = 0;
    while ((i >> (n + 1)) != 0) n = n + 1;
    y   = (i << 30) >> n;
    res = longint'(n) << 30;
    for (b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y   = y >> 1;
        res = res | (64'd1 << b);
      end
    end
    return res;
  endfunction

  function automatic longint unsigned exp2_q30(input longint unsigned g);
    longint unsigned root [31];
    longint unsigned r;
    int              k;
    root[0] = 64'd1 << 31;
    for (k = 1; k <= 30; k++) root[k] = isqrt64(root[k-1] << 30);
    r = 64'd1 << 30;
    for (k = 1; k <= 30; k++) begin
      if (((g >> (30 - k)) & 64'd1) != 0) r = (r * root[k] + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

  // entry i of a table of x^(e4/10000) over 0..1 with 2^tbits steps
  function automatic int pow_rom_entry(input int i, input int tbits, input int e4);
    longint unsigned mag;
    longint unsigned q;
    longint unsigned ip;
    longint unsigned f;
    longint unsigned m;
    longint unsigned sh;
    longint unsigned s;
    if (i == 0) return 0;
    mag = (longint'(tbits) << 30) - log2_q30(longint'(i));
    q   = (mag * longint'(e4) + 5000) / 10000;
    ip  = q >> 30;
    f   = q & ((64'd1 << 30) - 1);
    if (f == 0) begin
      m  = 64'd1 << 30;
      sh = ip;
    end else begin
      m  = exp2_q30((64'd1 << 30) - f);
      sh = ip + 1;
    end
    s = 30 + sh;
    if (s >= 63) return 0;
    return int'(((m << FRAC_BITS) + (64'd1 << (s - 1))) >> s);
  endfunction

endpackage

`default_nettype wire

>>> sv/pcg_if.sv
// pcg_in_if / pcg_out_if: valid-ready pixel channels of the grading core
// depends on pcg_pkg for the pixel type
`default_nettype none

interface pcg_in_if
  import pcg_pkg::*;
();
  logic valid;
  logic ready;
  pix_t red_in;
  pix_t green_in;
  pix_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface pcg_out_if
  import pcg_pkg::*;
();
  logic valid;
  logic ready;
  pix_t red_out;
  pix_t green_out;
  pix_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

`default_nettype wire

>>> sv/preset_color_grading_core.sv
// preset_color_grading_core: per-pixel color grading with three fixed presets
// depends on pcg_pkg, pcg_in_if / pcg_out_if and pcg_curve
//
// Usage: pixels enter on pix_in (red_in, green_in, blue_in, unsigned Q1.12,
// 4096 = 1.0) and leave on pix_out (red_out, green_out, blue_out, clamped to
// 0..1). A beat moves when valid and ready are both high. The preset is set
// by grade_preset_we / grade_preset_wdata (0 punchy, 1 soft warm, 2 or 3
// stylized cool) and must only change while no pixel is in flight.
// Throughput: one pixel per clock while pix_out accepts. The pixel passes
// through the seven-register datapath, whose first register loads at the
// input beat and whose last drives the output (capture and curve read,
// interpolation, curve select and gain, luminance, saturation, tint, clamp).
// Stalls: when pix_out is held off, the whole pipeline freezes and pix_in
// ready drops; no beat is dropped or repeated. Bubbles flow through freely.
// Reset (rst, synchronous) clears all stage valid bits and sets preset 0;
// the power tables are constant and need no fill.
`default_nettype none

module preset_color_grading_core
  import pcg_pkg::*;
#(
  parameter int POW_TABLE_BITS = POW_TABLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       grade_preset_we,
  input  wire logic [1:0] grade_preset_wdata,
  pcg_in_if.sink          pix_in,
  pcg_out_if.source       pix_out
);

  localparam int STAGES = 7;

  typedef struct packed {
    val_t r;
    val_t g;
    val_t b;
    val_t l;
    val_t sh;
  } stage_t;

  logic [1:0]        grade_preset;
  logic [STAGES-1:0] vld;
  logic              adv;
  logic              is_punchy;
  stage_t            s1, s2, s3, s4, s5, s6;
  stage_t            s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
  pix_t              cw_r, cw_g, cw_b, cc_r, cc_g, cc_b;
  pix_t              out_r, out_g, out_b;

  // preset register
  always_ff @(posedge clk) begin
    if (rst) begin
      grade_preset <= PRESET_PUNCHY;
    end else if (grade_preset_we) begin
      grade_preset <= grade_preset_wdata;
    end
  end

  assign is_punchy = (grade_preset == PRESET_PUNCHY);

  // global advance: the pipeline moves unless the output beat is stalled
  assign adv          = !vld[STAGES-1] || pix_out.ready;
  assign pix_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], pix_in.valid};
    end
  end

  // power curves, aligned with stage two
  pcg_curve #(.POW_TABLE_BITS(POW_TABLE_BITS), .EXP_E4(EXP_P092)) u_cw_r (
    .clk(clk), .en(adv), .x(pix_in.red_in), .y(cw_r));
  pcg_curve #(.POW_TABLE_BITS(POW_TABLE_BITS), .EXP_E4(EXP_P092)) u_cw_g (
    .clk(clk), .en(adv), .x(pix_in.green_in), .y(cw_g));
  pcg_curve #(.POW_TABLE_BITS(POW_TABLE_BITS), .EXP_E4(EXP_P092)) u_cw_b (
    .clk(clk), .en(adv), .x(pix_in.blue_in), .y(cw_b));
  pcg_curve #(.POW_TABLE_BITS(POW_TABLE_BITS), .EXP_E4(EXP_P108)) u_cc_r (
    .clk(clk), .en(adv), .x(pix_in.red_in), .y(cc_r));
  pcg_curve #(.POW_TABLE_BITS(POW_TABLE_BITS), .EXP_E4(EXP_P104)) u_cc_g (
    .clk(clk), .en(adv), .x(pix_in.green_in), .y(cc_g));
  pcg_curve #(.POW_TABLE_BITS(POW_TABLE_BITS), .EXP_E4(EXP_P096)) u_cc_b (
    .clk(clk), .en(adv), .x(pix_in.blue_in), .y(cc_b));

  // stage 1: capture pixel, luminance for the punchy preset
  always_comb begin
    s1_next.r  = to_val(pix_in.red_in);
    s1_next.g  = to_val(pix_in.green_in);
    s1_next.b  = to_val(pix_in.blue_in);
    s1_next.l  = luma(s1_next.r, s1_next.g, s1_next.b);
    s1_next.sh = '0;
  end

  // stage 2: punchy saturation, other presets wait for the curve interpolation
  always_comb begin
    s2_next = s1;
    if (is_punchy) begin
      s2_next.r = s1.l + mulk(s1.r - s1.l, K_SAT0);
      s2_next.g = s1.l + mulk(s1.g - s1.l, K_SAT0);
      s2_next.b = s1.l + mulk(s1.b - s1.l, K_SAT0);
    end
  end

  // stage 3: punchy contrast about one half, warm curves, or cool curves with gains
  always_comb begin
    s3_next = s2;
    unique case (grade_preset)
      PRESET_PUNCHY: begin
        s3_next.r = mulk(s2.r - HALF_V, K_CON0) + HALF_V;
        s3_next.g = mulk(s2.g - HALF_V, K_CON0) + HALF_V;
        s3_next.b = mulk(s2.b - HALF_V, K_CON0) + HALF_V;
      end
      PRESET_WARM: begin
        s3_next.r = to_val(cw_r);
        s3_next.g = to_val(cw_g);
        s3_next.b = to_val(cw_b);
      end
      default: begin
        s3_next.r = mulk(to_val(cc_r), K_G2_R);
        s3_next.g = mulk(to_val(cc_g), K_G2_G);
        s3_next.b = mulk(to_val(cc_b), K_G2_B);
      end
    endcase
  end

  // stage 4: punchy gains, or luminance of the curved pixel
  always_comb begin
    s4_next = s3;
    if (is_punchy) begin
      s4_next.r = mulk(s3.r, K_RG0);
      s4_next.b = mulk(s3.b, K_BG0);
    end else begin
      s4_next.l = luma(s3.r, s3.g, s3.b);
    end
  end

  // stage 5: saturation about luminance and shadow weight for warm and cool; punchy passes through
  always_comb begin
    s5_next = s4;
    unique case (grade_preset)
      PRESET_PUNCHY: begin
        s5_next = s4;
      end
      PRESET_WARM: begin
        s5_next.r  = s4.l + mulk(s4.r - s4.l, K_SAT1);
        s5_next.g  = s4.l + mulk(s4.g - s4.l, K_SAT1);
        s5_next.b  = s4.l + mulk(s4.b - s4.l, K_SAT1);
        s5_next.sh = ONE_V - s4.l;
      end
      default: begin
        s5_next.r  = s4.l + mulk(s4.r - s4.l, K_SAT2);
        s5_next.g  = s4.l + mulk(s4.g - s4.l, K_SAT2);
        s5_next.b  = s4.l + mulk(s4.b - s4.l, K_SAT2);
        s5_next.sh = ONE_V - clamp01(s4.l);
      end
    endcase
  end

  // stage 6: shadow and highlight tints for warm and cool (warm blue gets only the shadow tint); punchy passes through
  always_comb begin
    s6_next = s5;
    unique case (grade_preset)
      PRESET_PUNCHY: begin
        s6_next = s5;
      end
      PRESET_WARM: begin
        s6_next.r = s5.r + mulk(s5.sh, K_SH1_R) + mulk(s5.l, K_HL1_R);
        s6_next.g = s5.g + mulk(s5.sh, K_SH1_G) + mulk(s5.l, K_HL1_G);
        s6_next.b = s5.b + mulk(s5.sh, K_SH1_B);
      end
      default: begin
        s6_next.r = s5.r + mulk(s5.sh, K_SH2_R) + mulk(s5.l, K_HL2_R);
        s6_next.g = s5.g + mulk(s5.sh, K_SH2_G) + mulk(s5.l, K_HL2_G);
        s6_next.b = s5.b + mulk(s5.sh, K_SH2_B) + mulk(s5.l, K_HL2_B);
      end
    endcase
  end

  // datapath registers, stage 7 is the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      s4    <= s4_next;
      s5    <= s5_next;
      s6    <= s6_next;
      out_r <= PIX_W'(clamp01(s6.r));
      out_g <= PIX_W'(clamp01(s6.g));
      out_b <= PIX_W'(clamp01(s6.b));
    end
  end

  assign pix_out.valid     = vld[STAGES-1];
  assign pix_out.red_out   = out_r;
  assign pix_out.green_out = out_g;
  assign pix_out.blue_out  = out_b;

`ifndef SYNTH
  // output beats are always inside 0..1
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (pix_out.red_out <= PIX_W'(ONE) && pix_out.green_out <= PIX_W'(ONE)
                       && pix_out.blue_out <= PIX_W'(ONE)))
    else $error("graded channel above 1.0");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_out.valid)
    else $error("output valid right after reset");

  // a beat in stage six reaches the output when the pipeline advances
  a_valid_travel: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[STAGES-2]) |=> pix_out.valid)
    else $error("pixel lost between stage six and output");

  // no new pixel enters while the output beat is stalled
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.ready) |=> $stable(vld))
    else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

>>> sv/pcg_curve.sv
// pcg_curve: two-stage power curve, table read then linear interpolation
// depends on pcg_pkg (fixed-point helpers and table builder)
`default_nettype none

module pcg_curve
  import pcg_pkg::*;
#(
  parameter int POW_TABLE_BITS = POW_TABLE_BITS_DEF,
  parameter int EXP_E4         = EXP_P092
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire pix_t x,
  output pix_t      y
);

  localparam int ENTRIES = (1 << POW_TABLE_BITS) + 1;
  localparam int SHIFT   = FRAC_BITS - POW_TABLE_BITS;
  localparam int IDX_W   = POW_TABLE_BITS + 1;

  typedef pix_t rom_t [ENTRIES];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < ENTRIES; i++) t[i] = PIX_W'(pow_rom_entry(i, POW_TABLE_BITS, EXP_E4));
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  pix_t                 x_c;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_hi;
  logic [FRAC_BITS-1:0] fr_c;
  pix_t                 lo;
  pix_t                 hi;
  logic [FRAC_BITS-1:0] fr;
  val_t                 diff;

  // clamp to 0..1 and split into table index and position fraction
  always_comb begin
    x_c    = (x > PIX_W'(ONE)) ? PIX_W'(ONE) : x;
    idx    = x_c[PIX_W-1:SHIFT];
    idx_hi = (idx == IDX_W'(ENTRIES - 1)) ? idx : idx + 1'b1;
    fr_c   = FRAC_BITS'(x_c[SHIFT-1:0]) << POW_TABLE_BITS;
  end

  // table read
  always_ff @(posedge clk) begin
    if (en) begin
      lo <= ROM[idx];
      hi <= ROM[idx_hi];
      fr <= fr_c;
    end
  end

  // interpolation
  assign diff = to_val(hi) - to_val(lo);

  always_ff @(posedge clk) begin
    if (en) begin
      y <= PIX_W'(to_val(lo) + mulk(diff, coef_t'({{(K_W-FRAC_BITS){1'b0}}, fr})));
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: self-checking testbench for preset_color_grading_core
// depends on pcg_pkg and pcg_in_if / pcg_out_if; predicts each graded pixel in fixed point
// and compares it with the core output under random idling, stalls and preset changes
`default_nettype none

module tb_top;
  import pcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAB_N = 257;
  // curve table slots
  localparam int CRV_092 = 0;
  localparam int CRV_108 = 1;
  localparam int CRV_104 = 2;
  localparam int CRV_096 = 3;
  // stylized cool preset and its alias
  localparam logic [1:0] PRESET_COOL     = 2'd2;
  localparam logic [1:0] PRESET_COOL_ALT = 2'd3;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic grade_we = 1'b0;
  logic [1:0] grade_wdata = PRESET_PUNCHY;

  pcg_in_if in_ch ();
  pcg_out_if out_ch ();

  preset_color_grading_core u_top (
    .clk(clk),
    .rst(rst),
    .grade_preset_we(grade_we),
    .grade_preset_wdata(grade_wdata),
    .pix_in(in_ch.sink),
    .pix_out(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_t pend_px[$];
  rgb_t graded_q[$];
  longint pow_tab[4][TAB_N];
  longint unsigned half_root[31];
  logic [1:0] preset_q = PRESET_PUNCHY;
  int errs = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;

  // power table generation, Q30 log/exp
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned acc, bt, rem;
    rem = v;
    acc = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= acc + bt) begin
        rem = rem - acc - bt;
        acc = (acc >> 1) + bt;
      end else begin
        acc = acc >> 1;
      end
      bt = bt >> 2;
    end
    return acc;
  endfunction

  function automatic longint unsigned lg2_q30(input longint unsigned i);
    int n;
    longint unsigned y, acc;
    n = 0;
    while ((i >> (n + 1)) != 0) n++;
    y = (i << 30) >> n;
    acc = longint'(n) << 30;
    for (int b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        acc = acc | (64'd1 << b);
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned ex2_q30(input longint unsigned g);
    longint unsigned acc;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 30; k++)
      if (g[30-k]) acc = (acc * half_root[k] + (64'd1 << 29)) >> 30;
    return acc;
  endfunction

  function automatic longint curve_point(input int i, input longint unsigned e4);
    longint unsigned mag, q, ip, fr, m, sh;
    if (i == 0) return 0;
    mag = (longint'(8) << 30) - lg2_q30(i);
    q = (mag * e4 + 5000) / 10000;
    ip = q >> 30;
    fr = q & ((64'd1 << 30) - 1);
    if (fr == 0) begin
      m = 64'd1 << 30;
      sh = ip;
    end else begin
      m = ex2_q30((64'd1 << 30) - fr);
      sh = ip + 1;
    end
    if (30 + sh >= 63) return 0;
    return longint'(((m << 12) + (64'd1 << (29 + sh))) >> (30 + sh));
  endfunction

  // fixed-point helpers
  function automatic longint qc(input longint e4);
    return (e4 * 4096 + 5000) / 10000;
  endfunction

  function automatic longint rmul(input longint a, input longint k);
    longint p, m;
    p = a * k;
    m = (p < 0) ? -p : p;
    m = (m + 2048) >>> 12;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint sat01(input longint v);
    return (v < 0) ? 0 : (v > 4096) ? 4096 : v;
  endfunction

  function automatic longint lum(input longint r, input longint g, input longint b);
    return rmul(r, qc(2126)) + rmul(g, qc(7152)) + rmul(b, qc(722));
  endfunction

  function automatic longint pow_read(input int t, input longint x);
    longint pos, idx, fr;
    pos = sat01(x) << 8;
    idx = pos >>> 12;
    fr = pos & 4095;
    if (idx >= 256) return pow_tab[t][256];
    return pow_tab[t][idx] + rmul(pow_tab[t][idx+1] - pow_tab[t][idx], fr);
  endfunction

  // graded pixel for the current preset
  function automatic rgb_t grade_pixel(input rgb_t px, input logic [1:0] preset);
    longint r, g, b, l, sh;
    rgb_t res;
    r = px.r;
    g = px.g;
    b = px.b;
    if (preset == PRESET_PUNCHY) begin
      l = lum(r, g, b);
      r = l + rmul(r - l, qc(10800));
      g = l + rmul(g - l, qc(10800));
      b = l + rmul(b - l, qc(10800));
      r = rmul(r - 2048, qc(10600)) + 2048;
      g = rmul(g - 2048, qc(10600)) + 2048;
      b = rmul(b - 2048, qc(10600)) + 2048;
      r = rmul(r, qc(10150));
      b = rmul(b, qc(9850));
    end else if (preset == PRESET_WARM) begin
      r = pow_read(CRV_092, r);
      g = pow_read(CRV_092, g);
      b = pow_read(CRV_092, b);
      l = lum(r, g, b);
      r = l + rmul(r - l, qc(8800));
      g = l + rmul(g - l, qc(8800));
      b = l + rmul(b - l, qc(8800));
      sh = 4096 - l;
      r += rmul(sh, qc(150)) + rmul(l, qc(450));
      g += rmul(sh, qc(350)) + rmul(l, qc(250));
      b += rmul(sh, qc(500));
    end else begin
      r = rmul(pow_read(CRV_108, r), qc(8000));
      g = rmul(pow_read(CRV_104, g), qc(9300));
      b = rmul(pow_read(CRV_096, b), qc(11200));
      l = lum(r, g, b);
      r = l + rmul(r - l, qc(11800));
      g = l + rmul(g - l, qc(11800));
      b = l + rmul(b - l, qc(11800));
      sh = 4096 - sat01(l);
      r += rmul(sh, qc(180)) + rmul(l, qc(350));
      g += rmul(sh, qc(450)) + rmul(l, qc(200));
      b += rmul(sh, qc(1100)) + rmul(l, qc(450));
    end
    res.r = pix_t'(sat01(r));
    res.g = pix_t'(sat01(g));
    res.b = pix_t'(sat01(b));
    return res;
  endfunction

  function automatic pix_t rand_chan();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return pix_t'($urandom_range(0, 4096));
    if (sel < 9) return pix_t'($urandom);
    return (sel[0]) ? pix_t'(4096) : pix_t'(0);
  endfunction

  // preset register copy
  always @(posedge clk) begin
    if (grade_we) preset_q <= grade_wdata;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.red_in <= '0;
      in_ch.green_in <= '0;
      in_ch.blue_in <= '0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        graded_q.push_back(grade_pixel({in_ch.red_in, in_ch.green_in, in_ch.blue_in}, preset_q));
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pend_px.size() > 0) begin
          rgb_t nx;
          nx = pend_px.pop_front();
          in_ch.red_in <= nx.r;
          in_ch.green_in <= nx.g;
          in_ch.blue_in <= nx.b;
          in_ch.valid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= 60;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (graded_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected beat r=%0d g=%0d b=%0d",
                                   out_ch.red_out, out_ch.green_out, out_ch.blue_out);
        end else begin
          rgb_t want;
          want = graded_q.pop_front();
          if (want.r !== out_ch.red_out || want.g !== out_ch.green_out ||
              want.b !== out_ch.blue_out) begin
            errs++;
            if (errs <= 10)
              $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       want.r, want.g, want.b,
                       out_ch.red_out, out_ch.green_out, out_ch.blue_out);
          end
        end
      end
      if (hold_left > 0 || (hold_go && !hold_done)) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 6);
      end
    end
  end

  task automatic drain();
    while (pend_px.size() > 0 || in_ch.valid || graded_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_preset(input logic [1:0] v);
    drain();
    grade_we <= 1'b1;
    grade_wdata <= v;
    @(posedge clk);
    grade_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_directed();
    pend_px.push_back({pix_t'(0), pix_t'(0), pix_t'(0)});
    pend_px.push_back({pix_t'(4096), pix_t'(4096), pix_t'(4096)});
    pend_px.push_back({pix_t'(8191), pix_t'(8191), pix_t'(8191)});
    pend_px.push_back({pix_t'(4096), pix_t'(0), pix_t'(0)});
    pend_px.push_back({pix_t'(0), pix_t'(4096), pix_t'(0)});
    pend_px.push_back({pix_t'(0), pix_t'(0), pix_t'(4096)});
    pend_px.push_back({pix_t'(2048), pix_t'(2048), pix_t'(2048)});
    pend_px.push_back({pix_t'(4097), pix_t'(5000), pix_t'(8191)});
    pend_px.push_back({pix_t'(1), pix_t'(16), pix_t'(4095)});
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) pend_px.push_back({rand_chan(), rand_chan(), rand_chan()});
  endtask

  // test sequence
  initial begin
    logic [1:0] plan [7];
    plan = '{PRESET_PUNCHY, PRESET_WARM, PRESET_COOL, PRESET_COOL_ALT, PRESET_WARM,
             PRESET_COOL, PRESET_PUNCHY};
    in_ch.valid = 1'b0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
    half_root[0] = 64'd1 << 31;
    for (int k = 1; k <= 30; k++) half_root[k] = isqrt(half_root[k-1] << 30);
    for (int i = 0; i < TAB_N; i++) begin
      pow_tab[CRV_092][i] = curve_point(i, 9200);
      pow_tab[CRV_108][i] = curve_point(i, 10800);
      pow_tab[CRV_104][i] = curve_point(i, 10400);
      pow_tab[CRV_096][i] = curve_point(i, 9600);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 7; ph++) begin
      set_preset(plan[ph]);
      if (ph == 6) calm = 1'b1;
      add_directed();
      add_random(120);
      if (ph == 1) begin
        // stall the output while the input keeps offering pixels
        while (pend_px.size() > 80) @(posedge clk);
        hold_go = 1'b1;
      end
      if (ph == 2) begin
        // sender pause until the pipeline is empty
        drain();
      end
      add_random(120);
    end
    drain();

    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
